// ===== src/bth_pkg.sv =====
`default_nettype none

package bth_pkg;

    // Byte addresses are computed modulo 2**32; anything at or above the store
    // size reads as zero and ignores writes.
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned SIZE_W       = 16;
    localparam int unsigned CFG_W        = 13;
    localparam int unsigned REQ_W        = 12;
    localparam int unsigned OFF_W        = 12;

    localparam int unsigned HDR_BYTES    = 3;
    localparam int unsigned FTR_BYTES    = 2;
    localparam int unsigned TAG_BYTES    = HDR_BYTES + FTR_BYTES;
    localparam int unsigned FIRST_BLOCK  = 2;
    localparam int unsigned MIN_REGION   = 16;
    localparam int unsigned REGION_RESET = 4096;

    localparam logic [7:0] FLAG_FREE = 8'h00;
    localparam logic [7:0] FLAG_USED = 8'h01;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NULL      = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    // One byte or 16-bit little-endian access to the store.
    typedef struct packed {
        logic              valid;
        logic              write;
        logic              wide;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rdata;
    } mem_rsp_t;

endpackage

`default_nettype wire

// ===== src/bth_ifs.sv =====
`default_nettype none

interface bth_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] request_size;
    logic [11:0] block_offset;

    modport source (output valid, output opcode, output request_size, output block_offset,
                    input ready);
    modport sink (input valid, input opcode, input request_size, input block_offset,
                  output ready);
endinterface

interface bth_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] payload_offset;

    modport source (output valid, output status, output payload_offset, input ready);
    modport sink (input valid, input status, input payload_offset, output ready);
endinterface

`default_nettype wire

// ===== src/boundary_tag_heap_allocator_core.sv =====
// First-fit heap manager over an internal byte store with boundary tags.
// Channels: "request" carries opcode, request_size and block_offset; "result"
// carries status and payload_offset, one result for every request item.
// Both use valid/ready; an item moves when valid and ready are high at a
// rising clock edge. cfg_we/cfg_wdata write region_size, which formats the
// store as one free block; write it only while no item is in flight.
// Each store access goes through the single port of the byte memory.
// Allocate and check walk the block list; allocate then writes the tags of
// the block it takes. Null frees and checks and unknown opcodes go straight
// to the result. One item is worked on at a time.
// Reset: the store is cleared one byte a cycle, then formatted with a 4096-byte
// region (clamped to REGION_BYTES); request.ready stays low until then.
// Stall: a finished result waits in the output register; the next item can
// be accepted and worked on, and its result is held until the first is taken.
`default_nettype none

module boundary_tag_heap_allocator_core #(
    parameter int unsigned REGION_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bth_req_if.sink          request,
    bth_rsp_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);

    bth_pkg::mem_req_t mreq;
    bth_pkg::mem_rsp_t mrsp;

    bth_ctrl #(
        .REGION_BYTES (REGION_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mreq      (mreq),
        .mrsp      (mrsp)
    );

    bth_store #(
        .REGION_BYTES (REGION_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

endmodule

`default_nettype wire

// ===== src/bth_store.sv =====
`default_nettype none

module bth_store #(
    parameter int unsigned REGION_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bth_pkg::mem_req_t req,
    output bth_pkg::mem_rsp_t      rsp
);

    localparam int unsigned IDX_W = $clog2(REGION_BYTES);

    typedef enum logic [4:0] {
        SS_CLEAR = 5'b00001,
        SS_IDLE  = 5'b00010,
        SS_P0    = 5'b00100,
        SS_P1    = 5'b01000,
        SS_P2    = 5'b10000
    } sstate_t;

    sstate_t                       state_reg, state_next;
    bth_pkg::mem_req_t             op_reg;
    logic [IDX_W-1:0]              clr_cnt_reg;
    logic [7:0]                    lo_reg;
    logic [7:0]                    mem [REGION_BYTES];
    logic [7:0]                    mem_q_reg;
    logic                          q_in_reg;

    logic                          we, re, rd_in, done;
    logic [IDX_W-1:0]              widx, ridx;
    logic [7:0]                    wbyte, rdq;
    logic [bth_pkg::ADDR_W-1:0]    addr1;
    logic                          in0, in1;
    logic [bth_pkg::SIZE_W-1:0]    rdata;

    always_comb
    begin
        addr1      = op_reg.addr + 32'd1;
        in0        = op_reg.addr < bth_pkg::ADDR_W'(REGION_BYTES);
        in1        = addr1 < bth_pkg::ADDR_W'(REGION_BYTES);
        rdq        = q_in_reg ? mem_q_reg : 8'h00;
        we         = 1'b0;
        re         = 1'b0;
        rd_in      = in0;
        widx       = op_reg.addr[IDX_W-1:0];
        ridx       = op_reg.addr[IDX_W-1:0];
        wbyte      = op_reg.wdata[7:0];
        done       = 1'b0;
        rdata      = {8'h00, rdq};
        state_next = state_reg;
        case (state_reg)
            SS_CLEAR:
            begin
                we    = 1'b1;
                widx  = clr_cnt_reg;
                wbyte = 8'h00;
                if (clr_cnt_reg == IDX_W'(REGION_BYTES - 1))
                    state_next = SS_IDLE;
            end
            SS_IDLE:
            begin
                if (req.valid)
                    state_next = SS_P0;
            end
            SS_P0:
            begin
                if (op_reg.write)
                begin
                    we   = in0;
                    done = !op_reg.wide;
                end
                else
                    re = 1'b1;
                state_next = done ? SS_IDLE : SS_P1;
            end
            SS_P1:
            begin
                if (op_reg.write)
                begin
                    we    = in1;
                    widx  = addr1[IDX_W-1:0];
                    wbyte = op_reg.wdata[15:8];
                    done  = 1'b1;
                end
                else if (op_reg.wide)
                begin
                    re    = 1'b1;
                    rd_in = in1;
                    ridx  = addr1[IDX_W-1:0];
                end
                else
                    done = 1'b1;
                state_next = done ? SS_IDLE : SS_P2;
            end
            SS_P2:
            begin
                done       = 1'b1;
                rdata      = {rdq, lo_reg};
                state_next = SS_IDLE;
            end
            default:
                state_next = SS_IDLE;
        endcase
    end

    assign rsp.done  = done;
    assign rsp.rdata = rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SS_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SS_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SS_IDLE)
            op_reg <= req;
        if (state_reg == SS_P1)
            lo_reg <= rdq;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[widx] <= wbyte;
        if (re)
        begin
            mem_q_reg <= mem[ridx];
            q_in_reg  <= rd_in;
        end
    end

endmodule

`default_nettype wire

// ===== src/bth_ctrl.sv =====
`default_nettype none

module bth_ctrl #(
    parameter int unsigned REGION_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    bth_req_if.sink                request,
    bth_rsp_if.source              result,
    input  wire logic              cfg_we,
    input  wire logic [12:0]       cfg_wdata,
    output bth_pkg::mem_req_t      mreq,
    input  wire bth_pkg::mem_rsp_t mrsp
);

    localparam logic [16:0] REGION_MAX = 17'(REGION_BYTES);
    localparam logic [15:0] RESET_N    =
        16'((bth_pkg::REGION_RESET > REGION_BYTES) ? REGION_BYTES : bth_pkg::REGION_RESET);

    typedef enum logic [32:0] {
        S_IDLE   = 33'd1 << 0,
        S_F0     = 33'd1 << 1,
        S_F1     = 33'd1 << 2,
        S_F2     = 33'd1 << 3,
        S_F3     = 33'd1 << 4,
        S_A_END  = 33'd1 << 5,
        S_A_TEST = 33'd1 << 6,
        S_A_BSZ  = 33'd1 << 7,
        S_A_FLG  = 33'd1 << 8,
        S_A_S0   = 33'd1 << 9,
        S_A_S1   = 33'd1 << 10,
        S_A_S2   = 33'd1 << 11,
        S_A_U0   = 33'd1 << 12,
        S_A_U1   = 33'd1 << 13,
        S_A_U2   = 33'd1 << 14,
        S_R_END  = 33'd1 << 15,
        S_R_CLR  = 33'd1 << 16,
        S_R_CSZ  = 33'd1 << 17,
        S_R_NSZ  = 33'd1 << 18,
        S_R_NFL  = 33'd1 << 19,
        S_R_M0   = 33'd1 << 20,
        S_R_M1   = 33'd1 << 21,
        S_R_PREV = 33'd1 << 22,
        S_R_PSZ  = 33'd1 << 23,
        S_R_CSZ2 = 33'd1 << 24,
        S_R_PFL  = 33'd1 << 25,
        S_R_P0   = 33'd1 << 26,
        S_R_P1   = 33'd1 << 27,
        S_C_END  = 33'd1 << 28,
        S_C_FLG  = 33'd1 << 29,
        S_C_TEST = 33'd1 << 30,
        S_C_BSZ  = 33'd1 << 31,
        S_DONE   = 33'd1 << 32
    } cstate_t;

    cstate_t           state_reg, state_next;
    logic              fmt_pend_reg, fmt_pend_next;
    logic [15:0]       cfg_n_reg, cfg_n_next;
    logic [15:0]       fmt_n_reg, fmt_n_next;
    logic              out_valid_reg, out_valid_next;
    bth_pkg::status_t  out_status_reg, out_status_next;
    logic [11:0]       out_pay_reg, out_pay_next;
    bth_pkg::status_t  res_status_reg, res_status_next;
    logic [11:0]       res_pay_reg, res_pay_next;
    logic [15:0]       rq_reg, rq_next;
    logic [15:0]       rem_reg, rem_next;
    logic [11:0]       p_reg, p_next;
    logic [15:0]       end_reg, end_next;
    logic [16:0]       cur_reg, cur_next;
    logic [15:0]       bsz_reg, bsz_next;
    logic [15:0]       csz_reg, csz_next;
    logic [15:0]       nsz_reg, nsz_next;
    logic [15:0]       psz_reg, psz_next;
    logic              flag_reg, flag_next;

    logic [31:0]       p32, hdr, cur32;
    logic [16:0]       cn, cp, cfg_v;
    logic [15:0]       cfg_clamp, rd16, used, rem;
    logic [7:0]        rd8;
    logic              fits, in_ready;

    assign in_ready             = (state_reg == S_IDLE) && !fmt_pend_reg;
    assign request.ready        = in_ready;
    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.payload_offset = out_pay_reg;

    always_comb
    begin
        p32   = 32'(p_reg);
        hdr   = p32 - 32'(bth_pkg::HDR_BYTES);
        cur32 = 32'(cur_reg);
        cn    = {1'b0, csz_reg} + {1'b0, nsz_reg};
        cp    = {1'b0, csz_reg} + {1'b0, psz_reg};
        rd16  = mrsp.rdata;
        rd8   = mrsp.rdata[7:0];
        used  = rq_reg + 16'(bth_pkg::TAG_BYTES);
        rem   = bsz_reg - 16'(bth_pkg::TAG_BYTES) - rq_reg;
        fits  = (rd8 == bth_pkg::FLAG_FREE) &&
                ({1'b0, bsz_reg} >= {1'b0, rq_reg} + 17'(bth_pkg::TAG_BYTES));
        cfg_v = 17'(cfg_wdata);
        if (cfg_v < 17'(bth_pkg::MIN_REGION))
            cfg_clamp = 16'(bth_pkg::MIN_REGION);
        else if (cfg_v > REGION_MAX)
            cfg_clamp = REGION_MAX[15:0];
        else
            cfg_clamp = cfg_v[15:0];
    end

    // Store access issued by the current step; held until the store reports done.
    always_comb
    begin
        mreq       = '0;
        mreq.valid = 1'b1;
        mreq.wide  = 1'b1;
        case (state_reg)
            S_F0:
            begin
                mreq.write = 1'b1;
                mreq.wdata = fmt_n_reg;
            end
            S_F1:
            begin
                mreq.write = 1'b1;
                mreq.addr  = 32'(bth_pkg::FIRST_BLOCK);
                mreq.wdata = fmt_n_reg - 16'(bth_pkg::FIRST_BLOCK);
            end
            S_F2:
            begin
                mreq.write = 1'b1;
                mreq.wide  = 1'b0;
                mreq.addr  = 32'(bth_pkg::FIRST_BLOCK) + 32'd2;
                mreq.wdata = 16'(bth_pkg::FLAG_FREE);
            end
            S_F3:
            begin
                mreq.write = 1'b1;
                mreq.addr  = 32'(fmt_n_reg) - 32'd2;
                mreq.wdata = fmt_n_reg - 16'(bth_pkg::FIRST_BLOCK);
            end
            S_A_END, S_R_END, S_C_END:
                mreq.addr = '0;
            S_A_BSZ, S_C_BSZ:
                mreq.addr = cur32;
            S_A_FLG:
            begin
                mreq.wide = 1'b0;
                mreq.addr = cur32 + 32'd2;
            end
            S_A_S0:
            begin
                mreq.write = 1'b1;
                mreq.addr  = cur32 + 32'(rq_reg) + 32'(bth_pkg::TAG_BYTES);
                mreq.wdata = rem_reg;
            end
            S_A_S1:
            begin
                mreq.write = 1'b1;
                mreq.wide  = 1'b0;
                mreq.addr  = cur32 + 32'(rq_reg) + 32'(bth_pkg::TAG_BYTES) + 32'd2;
                mreq.wdata = 16'(bth_pkg::FLAG_FREE);
            end
            S_A_S2:
            begin
                mreq.write = 1'b1;
                mreq.addr  = cur32 + 32'(bsz_reg) - 32'(bth_pkg::FTR_BYTES);
                mreq.wdata = rem_reg;
            end
            S_A_U0:
            begin
                mreq.write = 1'b1;
                mreq.addr  = cur32;
                mreq.wdata = used;
            end
            S_A_U1:
            begin
                mreq.write = 1'b1;
                mreq.wide  = 1'b0;
                mreq.addr  = cur32 + 32'd2;
                mreq.wdata = 16'(bth_pkg::FLAG_USED);
            end
            S_A_U2:
            begin
                mreq.write = 1'b1;
                mreq.addr  = cur32 + 32'(bth_pkg::HDR_BYTES) + 32'(rq_reg);
                mreq.wdata = used;
            end
            S_R_CLR:
            begin
                mreq.write = 1'b1;
                mreq.wide  = 1'b0;
                mreq.addr  = p32 - 32'd1;
                mreq.wdata = 16'(bth_pkg::FLAG_FREE);
            end
            S_R_CSZ, S_R_CSZ2:
                mreq.addr = hdr;
            S_R_NSZ:
                mreq.addr = p32 + 32'(csz_reg) - 32'(bth_pkg::HDR_BYTES);
            S_R_NFL:
            begin
                mreq.wide = 1'b0;
                mreq.addr = p32 + 32'(csz_reg) - 32'd1;
            end
            S_R_M0:
            begin
                mreq.write = 1'b1;
                mreq.addr  = hdr;
                mreq.wdata = cn[15:0];
            end
            S_R_M1:
            begin
                mreq.write = 1'b1;
                mreq.addr  = hdr + 32'(cn) - 32'(bth_pkg::FTR_BYTES);
                mreq.wdata = cn[15:0];
            end
            S_R_PSZ:
                mreq.addr = p32 - 32'(bth_pkg::TAG_BYTES);
            S_R_PFL:
            begin
                mreq.wide = 1'b0;
                mreq.addr = p32 - 32'(psz_reg) - 32'd1;
            end
            S_R_P0:
            begin
                mreq.write = 1'b1;
                mreq.addr  = hdr - 32'(psz_reg);
                mreq.wdata = cp[15:0];
            end
            S_R_P1:
            begin
                mreq.write = 1'b1;
                mreq.addr  = hdr + 32'(csz_reg) - 32'(bth_pkg::FTR_BYTES);
                mreq.wdata = cp[15:0];
            end
            S_C_FLG:
            begin
                mreq.wide = 1'b0;
                mreq.addr = p32 - 32'd1;
            end
            default:
            begin
                mreq.valid = 1'b0;
                mreq.wide  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        fmt_pend_next   = fmt_pend_reg;
        cfg_n_next      = cfg_n_reg;
        fmt_n_next      = fmt_n_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_pay_next    = out_pay_reg;
        res_status_next = res_status_reg;
        res_pay_next    = res_pay_reg;
        rq_next         = rq_reg;
        rem_next        = rem_reg;
        p_next          = p_reg;
        end_next        = end_reg;
        cur_next        = cur_reg;
        bsz_next        = bsz_reg;
        csz_next        = csz_reg;
        nsz_next        = nsz_reg;
        psz_next        = psz_reg;
        flag_next       = flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                res_pay_next = '0;
                if (fmt_pend_reg)
                begin
                    fmt_pend_next = 1'b0;
                    fmt_n_next    = cfg_n_reg;
                    state_next    = S_F0;
                end
                else if (request.valid)
                begin
                    rq_next = 16'(request.request_size);
                    p_next  = request.block_offset;
                    case (bth_pkg::opcode_t'(request.opcode))
                        bth_pkg::OP_ALLOC:
                            state_next = S_A_END;
                        bth_pkg::OP_FREE:
                        begin
                            res_status_next = bth_pkg::ST_NULL;
                            state_next = (request.block_offset == '0) ? S_DONE : S_R_END;
                        end
                        bth_pkg::OP_CHECK:
                        begin
                            res_status_next = bth_pkg::ST_NULL;
                            state_next = (request.block_offset == '0) ? S_DONE : S_C_END;
                        end
                        default:
                        begin
                            res_status_next = bth_pkg::ST_OK;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_F0, S_F1, S_F2, S_R_M0, S_R_P0, S_A_S0, S_A_S1, S_A_S2, S_A_U0, S_A_U1:
            begin
                if (mrsp.done)
                begin
                    case (state_reg)
                        S_F0:    state_next = S_F1;
                        S_F1:    state_next = S_F2;
                        S_F2:    state_next = S_F3;
                        S_R_M0:  state_next = S_R_M1;
                        S_R_P0:  state_next = S_R_P1;
                        S_A_S0:  state_next = S_A_S1;
                        S_A_S1:  state_next = S_A_S2;
                        S_A_S2:  state_next = S_A_U0;
                        S_A_U0:  state_next = S_A_U1;
                        default: state_next = S_A_U2;
                    endcase
                end
            end
            S_F3:
            begin
                if (mrsp.done)
                    state_next = S_IDLE;
            end
            S_A_END:
            begin
                if (mrsp.done)
                begin
                    end_next   = rd16;
                    cur_next   = 17'(bth_pkg::FIRST_BLOCK);
                    state_next = S_A_TEST;
                end
            end
            S_A_TEST:
            begin
                if (cur_reg < {1'b0, end_reg})
                    state_next = S_A_BSZ;
                else
                begin
                    res_status_next = bth_pkg::ST_NO_FIT;
                    state_next      = S_DONE;
                end
            end
            S_A_BSZ:
            begin
                if (mrsp.done)
                begin
                    bsz_next   = rd16;
                    state_next = S_A_FLG;
                end
            end
            S_A_FLG:
            begin
                if (mrsp.done)
                begin
                    if (fits)
                    begin
                        rem_next = rem;
                        if (rem >= 16'(bth_pkg::TAG_BYTES))
                            state_next = S_A_S0;
                        else
                        begin
                            // Remainder too small for its own tags: it pads this block.
                            rq_next    = rq_reg + rem;
                            state_next = S_A_U0;
                        end
                    end
                    else if (bsz_reg == '0)
                    begin
                        res_status_next = bth_pkg::ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 17'(bsz_reg);
                        state_next = S_A_TEST;
                    end
                end
            end
            S_A_U2:
            begin
                if (mrsp.done)
                begin
                    res_status_next = bth_pkg::ST_OK;
                    res_pay_next    = cur_reg[11:0] + 12'(bth_pkg::HDR_BYTES);
                    state_next      = S_DONE;
                end
            end
            S_R_END:
            begin
                if (mrsp.done)
                begin
                    end_next   = rd16;
                    state_next = S_R_CLR;
                end
            end
            S_R_CLR:
            begin
                if (mrsp.done)
                    state_next = S_R_CSZ;
            end
            S_R_CSZ:
            begin
                if (mrsp.done)
                begin
                    csz_next = rd16;
                    if ((hdr + 32'(rd16)) != 32'(end_reg))
                        state_next = S_R_NSZ;
                    else
                        state_next = S_R_PREV;
                end
            end
            S_R_NSZ:
            begin
                if (mrsp.done)
                begin
                    nsz_next   = rd16;
                    state_next = S_R_NFL;
                end
            end
            S_R_NFL:
            begin
                if (mrsp.done)
                    state_next = (rd8 == bth_pkg::FLAG_FREE) ? S_R_M0 : S_R_PREV;
            end
            S_R_M1:
            begin
                if (mrsp.done)
                    state_next = S_R_PREV;
            end
            S_R_PREV:
            begin
                res_status_next = bth_pkg::ST_OK;
                if (hdr != 32'(bth_pkg::FIRST_BLOCK))
                    state_next = S_R_PSZ;
                else
                    state_next = S_DONE;
            end
            S_R_PSZ:
            begin
                if (mrsp.done)
                begin
                    psz_next   = rd16;
                    state_next = S_R_CSZ2;
                end
            end
            S_R_CSZ2:
            begin
                // The size is read again since a merge with the next block may change it.
                if (mrsp.done)
                begin
                    csz_next   = rd16;
                    state_next = S_R_PFL;
                end
            end
            S_R_PFL:
            begin
                if (mrsp.done)
                    state_next = (rd8 == bth_pkg::FLAG_FREE) ? S_R_P0 : S_DONE;
            end
            S_R_P1:
            begin
                if (mrsp.done)
                    state_next = S_DONE;
            end
            S_C_END:
            begin
                if (mrsp.done)
                begin
                    end_next = rd16;
                    if (17'(p_reg) > {1'b0, rd16})
                    begin
                        res_status_next = bth_pkg::ST_NOT_ALLOC;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_C_FLG;
                end
            end
            S_C_FLG:
            begin
                if (mrsp.done)
                begin
                    flag_next  = (rd8 == bth_pkg::FLAG_USED);
                    cur_next   = 17'(bth_pkg::FIRST_BLOCK);
                    state_next = S_C_TEST;
                end
            end
            S_C_TEST:
            begin
                if (cur_reg < {1'b0, end_reg})
                begin
                    if (flag_reg && (18'(cur_reg) + 18'(bth_pkg::HDR_BYTES) == 18'(p_reg)))
                    begin
                        res_status_next = bth_pkg::ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_C_BSZ;
                end
                else
                begin
                    res_status_next = bth_pkg::ST_NOT_ALLOC;
                    state_next      = S_DONE;
                end
            end
            S_C_BSZ:
            begin
                if (mrsp.done)
                begin
                    if (rd16 == '0)
                    begin
                        res_status_next = bth_pkg::ST_NOT_ALLOC;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 17'(rd16);
                        state_next = S_C_TEST;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pay_next    = res_pay_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cfg_we)
        begin
            cfg_n_next    = cfg_clamp;
            fmt_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fmt_pend_reg  <= 1'b1;
            cfg_n_reg     <= RESET_N;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fmt_pend_reg  <= fmt_pend_next;
            cfg_n_reg     <= cfg_n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_n_reg      <= fmt_n_next;
        out_status_reg <= out_status_next;
        out_pay_reg    <= out_pay_next;
        res_status_reg <= res_status_next;
        res_pay_reg    <= res_pay_next;
        rq_reg         <= rq_next;
        rem_reg        <= rem_next;
        p_reg          <= p_next;
        end_reg        <= end_next;
        cur_reg        <= cur_next;
        bsz_reg        <= bsz_next;
        csz_reg        <= csz_next;
        nsz_reg        <= nsz_next;
        psz_reg        <= psz_next;
        flag_reg       <= flag_next;
    end

    a_no_access_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mreq.valid)
        else $error("store access issued while taking a new item");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    a_format_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && fmt_pend_reg) |=> (state_reg == S_F0))
        else $error("pending format not started");

endmodule

`default_nettype wire
